@@ rtl/core/c2f_pkg.sv @@
// Shared types and constants for the clamped 2-D convolution filter.
package c2f_pkg;

  localparam int PIX_BITS        = 8;
  localparam int COEFF_BITS      = 12;
  localparam int COEFF_ROWS      = 5;
  localparam int COEFF_PER_ROW   = 5;
  localparam int GEOM_BITS       = 11;
  localparam int RADIUS_BITS     = 2;
  localparam int RADIUS_LIMIT    = 2;
  localparam int MAX_HEIGHT      = 1024;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = COEFF_BITS * COEFF_PER_ROW;

  localparam int KERNEL_MAX_DEF      = 5;
  localparam int MAX_WIDTH_DEF       = 1024;
  localparam int COEFF_FRAC_BITS_DEF = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEFF0 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEFF1 = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEFF2 = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEFF3 = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEFF4 = 3'd7;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel_in;
    logic                flush;
  } c2f_in_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel_out;
    logic                frame_last;
  } c2f_out_t;

endpackage

@@ rtl/core/conv2d_clamped_filter.sv @@
// Streaming 2-D convolution filter with line memory, window and clamped output.
//
// Pixels enter on the in channel (in_valid/in_stall, in_data) in raster order, at
// most one per clock. Results leave on the out channel (out_valid/out_stall,
// out_data). Output k of a frame is produced by input item k + r*W + r; after
// the W*H pixels, flush items push out the tail, and the last result carries
// frame_last. A flush during the pixel phase is taken and dropped.
// Throughput is one item per clock unless stalled; every item does one read and one
// write of the column line memory, with forwarding when consecutive items hit the
// same column. Results pass stage 1, window, product, row-sum and output registers.
// Geometry and radius are sampled on the first item of a frame; coefficients
// are used live. Configuration goes through cfg_we/cfg_index/cfg_data while
// the block is idle.
// Reset (rst, synchronous) empties the pipeline and restarts the frame; the
// line memory needs no clearing since rows outside the frame are masked.
// When out_stall is high, results stay in the output register and the
// pipeline stages in front keep filling until all are held, then in_stall rises.
module conv2d_clamped_filter #(
  parameter int KERNEL_MAX      = c2f_pkg::KERNEL_MAX_DEF,
  parameter int MAX_WIDTH       = c2f_pkg::MAX_WIDTH_DEF,
  parameter int COEFF_FRAC_BITS = c2f_pkg::COEFF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  c2f_pkg::c2f_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output c2f_pkg::c2f_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [c2f_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [c2f_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int HALF  = (KERNEL_MAX - 1) / 2;
  localparam int RCAP  = (HALF > c2f_pkg::RADIUS_LIMIT) ? c2f_pkg::RADIUS_LIMIT : HALF;
  localparam int WIN   = 2 * RCAP + 1;
  localparam int LINES = (WIN > 1) ? WIN - 1 : 1;
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = c2f_pkg::GEOM_BITS;
  localparam int RB    = c2f_pkg::RADIUS_BITS;
  localparam int PB    = c2f_pkg::PIX_BITS;
  localparam int CB    = c2f_pkg::COEFF_BITS;
  localparam int PW    = PB + CB + 1;
  localparam int RSW   = PW + 3;
  localparam int SW    = RSW + 3;
  localparam int LW    = PB * LINES;

  // configuration registers
  logic [RB-1:0]                     kernel_radius;
  logic [c2f_pkg::GEOM_BITS-1:0]     image_width;
  logic [c2f_pkg::GEOM_BITS-1:0]     image_height;
  logic [c2f_pkg::CFG_DATA_BITS-1:0] coeff_row [c2f_pkg::COEFF_ROWS];

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_radius <= RB'(1);
      image_width   <= c2f_pkg::GEOM_BITS'(1024);
      image_height  <= c2f_pkg::GEOM_BITS'(1024);
      for (int i = 0; i < c2f_pkg::COEFF_ROWS; i++) begin
        coeff_row[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        c2f_pkg::REG_RADIUS: kernel_radius <= cfg_data[RB-1:0];
        c2f_pkg::REG_WIDTH:  image_width   <= cfg_data[c2f_pkg::GEOM_BITS-1:0];
        c2f_pkg::REG_HEIGHT: image_height  <= cfg_data[c2f_pkg::GEOM_BITS-1:0];
        c2f_pkg::REG_COEFF0: coeff_row[0]  <= cfg_data;
        c2f_pkg::REG_COEFF1: coeff_row[1]  <= cfg_data;
        c2f_pkg::REG_COEFF2: coeff_row[2]  <= cfg_data;
        c2f_pkg::REG_COEFF3: coeff_row[3]  <= cfg_data;
        c2f_pkg::REG_COEFF4: coeff_row[4]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [WW-1:0] cfg_w;
  logic [HW-1:0] cfg_h;
  logic [RB-1:0] cfg_r;

  always_comb begin
    if (image_width == '0) begin
      cfg_w = WW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      cfg_w = WW'(MAX_WIDTH);
    end else begin
      cfg_w = WW'(image_width);
    end
    if (image_height == '0) begin
      cfg_h = HW'(1);
    end else if (int'(image_height) > c2f_pkg::MAX_HEIGHT) begin
      cfg_h = HW'(c2f_pkg::MAX_HEIGHT);
    end else begin
      cfg_h = HW'(image_height);
    end
    cfg_r = (int'(kernel_radius) > RCAP) ? RB'(RCAP) : kernel_radius;
  end

  // frame position
  logic          started;
  logic [WW-1:0] frame_w;
  logic [HW-1:0] frame_h;
  logic [RB-1:0] frame_r;
  logic [CW-1:0] in_col;
  logic [HW-1:0] in_row;
  logic [CW-1:0] out_x;
  logic [HW-1:0] out_y;

  logic [WW-1:0] cur_w;
  logic [HW-1:0] cur_h;
  logic [RB-1:0] cur_r;
  logic          pix_phase, drop, accept, proc, emit, last_item, col_wrap, x_wrap;
  logic [CW:0]   col_inc, x_inc;
  logic [WIN-1:0] rmask, cmask;
  logic [HW-1:0] emit_row;
  logic [CW-1:0] emit_col;

  // pipeline control
  logic v1, v2, v3, v4;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, o_rdy;
  logic s2_emit;

  assign o_rdy    = !out_valid || !out_stall;
  assign s4_rdy   = !v4 || o_rdy;
  assign s3_rdy   = !v3 || s4_rdy;
  assign s2_rdy   = !v2 || !s2_emit || s3_rdy;
  assign s1_rdy   = !v1 || s2_rdy;
  assign in_stall = !s1_rdy;

  assign cur_w = started ? frame_w : cfg_w;
  assign cur_h = started ? frame_h : cfg_h;
  assign cur_r = started ? frame_r : cfg_r;

  // first emitting position is item r*W + r; a one-column frame reaches it at row 2r
  assign emit_row  = (cur_w == WW'(1)) ? HW'({cur_r, 1'b0}) : HW'(cur_r);
  assign emit_col  = (cur_w == WW'(1)) ? '0 : CW'(cur_r);

  assign pix_phase = in_row < cur_h;
  assign drop      = pix_phase && in_data.flush;
  assign accept    = in_valid && !in_stall;
  assign proc      = accept && !drop;
  assign emit      = (in_row > emit_row) || ((in_row == emit_row) && (in_col >= emit_col));
  assign col_inc   = {1'b0, in_col} + 1'b1;
  assign x_inc     = {1'b0, out_x} + 1'b1;
  assign col_wrap  = col_inc == (CW+1)'(cur_w);
  assign x_wrap    = x_inc == (CW+1)'(cur_w);
  assign last_item = emit && x_wrap && (out_y + 1'b1 == cur_h);

  always_comb begin
    int xx, yy;
    for (int j = 0; j < WIN; j++) begin
      xx = int'(out_x) + int'(cur_r) - j;
      yy = int'(out_y) + int'(cur_r) - j;
      cmask[j] = (j <= 2 * int'(cur_r)) && (xx >= 0) && (xx < int'(cur_w));
      rmask[j] = (j <= 2 * int'(cur_r)) && (yy >= 0) && (yy < int'(cur_h));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      frame_w <= WW'(1);
      frame_h <= HW'(1);
      frame_r <= '0;
      in_col  <= '0;
      in_row  <= '0;
      out_x   <= '0;
      out_y   <= '0;
    end else if (proc) begin
      if (last_item) begin
        started <= 1'b0;
        in_col  <= '0;
        in_row  <= '0;
        out_x   <= '0;
        out_y   <= '0;
      end else begin
        started <= 1'b1;
        frame_w <= cur_w;
        frame_h <= cur_h;
        frame_r <= cur_r;
        if (col_wrap) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= col_inc[CW-1:0];
        end
        if (emit) begin
          if (x_wrap) begin
            out_x <= '0;
            out_y <= out_y + 1'b1;
          end else begin
            out_x <= x_inc[CW-1:0];
          end
        end
      end
    end
  end

  // stage 1: item registered, line memory read in flight
  logic [PB-1:0]  s1_pix;
  logic [CW-1:0]  s1_col;
  logic           s1_emit, s1_last;
  logic [WIN-1:0] s1_rmask, s1_cmask;
  logic [RB-1:0]  s1_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_rdy) begin
      v1 <= proc;
    end
    if (s1_rdy) begin
      s1_pix   <= in_data.flush ? '0 : in_data.pixel_in;
      s1_col   <= in_col;
      s1_emit  <= emit;
      s1_last  <= last_item;
      s1_rmask <= rmask;
      s1_cmask <= cmask;
      s1_r     <= cur_r;
    end
  end

  // line memory: one entry per column holds the pixels of the rows above
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] rd_q, fwd_q, old_col, wr_data;
  logic [CW-1:0] rd_addr;
  logic          wr_en, hit_q;
  logic [PB-1:0] col_vec [WIN];

  assign rd_addr = s1_rdy ? in_col : s1_col;
  assign wr_en   = v1 && s2_rdy;
  assign old_col = hit_q ? fwd_q : rd_q;

  always_comb begin
    wr_data = old_col << PB;
    wr_data[PB-1:0] = s1_pix;
    col_vec[0] = s1_pix;
    for (int i = 1; i < WIN; i++) begin
      col_vec[i] = old_col[PB*(i-1) +: PB];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[s1_col] <= wr_data;
    end
    rd_q  <= line_mem[rd_addr];
    fwd_q <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= wr_en && (s1_col == rd_addr);
    end
  end

  // stage 2: window shift register
  logic [PB-1:0]  win [WIN][WIN];
  logic           s2_last;
  logic [WIN-1:0] s2_rmask, s2_cmask;
  logic [RB-1:0]  s2_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_rdy) begin
      v2 <= v1;
    end
    if (wr_en) begin
      for (int i = 0; i < WIN; i++) begin
        win[i][0] <= col_vec[i];
        for (int j = 1; j < WIN; j++) begin
          win[i][j] <= win[i][j-1];
        end
      end
      s2_emit  <= s1_emit;
      s2_last  <= s1_last;
      s2_rmask <= s1_rmask;
      s2_cmask <= s1_cmask;
      s2_r     <= s1_r;
    end
  end

  // stage 3: products
  logic signed [PW-1:0] prod [WIN][WIN];
  logic signed [PW-1:0] prod_next [WIN][WIN];
  logic                 s3_last;

  always_comb begin
    logic [2:0]           ri, cj;
    logic signed [CB-1:0] coef;
    logic signed [PB:0]   pix;
    logic signed [PW-1:0] prod_raw;
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        ri   = 3'(2 * int'(s2_r) - i);
        cj   = 3'(2 * int'(s2_r) - j);
        coef = $signed(coeff_row[ri][CB*cj +: CB]);
        pix  = $signed({1'b0, win[i][j]});
        prod_raw = pix * coef;
        prod_next[i][j] = (s2_rmask[i] && s2_cmask[j]) ? prod_raw : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (s3_rdy) begin
      v3 <= v2 && s2_emit;
    end
    if (s3_rdy) begin
      prod    <= prod_next;
      s3_last <= s2_last;
    end
  end

  // stage 4: row sums
  logic signed [RSW-1:0] row_sum [WIN];
  logic signed [RSW-1:0] row_sum_next [WIN];
  logic                  s4_last;

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      row_sum_next[i] = '0;
      for (int j = 0; j < WIN; j++) begin
        row_sum_next[i] = row_sum_next[i] + RSW'(prod[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (s4_rdy) begin
      v4 <= v3;
    end
    if (s4_rdy) begin
      row_sum <= row_sum_next;
      s4_last <= s3_last;
    end
  end

  // stage 5: total, clamp, output register
  logic signed [SW-1:0] total;
  logic [SW-1:0]        quot;
  logic [PB-1:0]        clamped;

  always_comb begin
    total = '0;
    for (int i = 0; i < WIN; i++) begin
      total = total + SW'(row_sum[i]);
    end
    quot = SW'(total >>> COEFF_FRAC_BITS);
    if (total < 0) begin
      clamped = '0;
    end else if (quot > SW'({PB{1'b1}})) begin
      clamped = '1;
    end else begin
      clamped = quot[PB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_rdy) begin
      out_valid <= v4;
    end
    if (o_rdy) begin
      out_data.pixel_out  <= clamped;
      out_data.frame_last <= s4_last;
    end
  end

`ifndef SYNTHESIS
  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    !started |-> (in_col == '0) && (in_row == '0) && (out_x == '0) && (out_y == '0))
    else $error("frame counters not cleared between frames");

  a_tail_after_pixels: assert property (@(posedge clk) disable iff (rst)
    (proc && last_item && (cur_r != '0)) |-> !pix_phase)
    else $error("last result issued inside the pixel phase with nonzero radius");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    started |-> ({1'b0, in_col} < (CW+1)'(frame_w)) && ({1'b0, out_x} < (CW+1)'(frame_w)))
    else $error("column counter beyond frame width");
`endif

endmodule
